// ===== rtl/stwe_pkg.sv =====
// stwe_pkg: shared constants, register indexes and the quarter-wave sine table
// for the sine tone generator with envelope.
// No dependencies.
package stwe_pkg;

	// phase accumulator and sine table geometry
	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 8;
	localparam int TAB_N           = 1 << SINE_TABLE_BITS;
	localparam int TAB_AW          = SINE_TABLE_BITS + 1;

	// field widths
	localparam int STEP_W   = 32;
	localparam int LEN_W    = 16;
	localparam int ASTEP_W  = 16;
	localparam int ENV_W    = 22;
	localparam int SINE_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 22;

	// pi/2 in Q30 and the envelope ceiling
	localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;
	localparam logic [ENV_W-1:0] ENV_MAX     = {ENV_W{1'b1}};

	// register reset values
	localparam logic [LEN_W-1:0]   NOTE_LEN_RST    = 16'd20000;
	localparam logic [ASTEP_W-1:0] ATTACK_STEP_RST = 16'd307;
	localparam logic [ASTEP_W-1:0] DECAY_STEP_RST  = 16'd154;
	localparam logic [ENV_W-1:0]   START_LEVEL_RST = 22'd307;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_NOTE_LENGTH = 2'd0,
		REG_ATTACK_STEP = 2'd1,
		REG_DECAY_STEP  = 2'd2,
		REG_START_LEVEL = 2'd3
	} cfg_reg_t;

	// quarter-wave table, 0 to pi/2 inclusive, Q1.15
	typedef logic [SINE_W-1:0] sine_rom_t [0:TAB_N];

	// Q30 Taylor series of sin with eight correction terms, truncated per step
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] v;
		for (int k = 0; k <= TAB_N; k++) begin
			x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
			sum  = x;
			term = x;
			for (int j = 1; j <= 8; j++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / 64'((2 * j) * (2 * j + 1));
				if ((j & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			rom[k] = SINE_W'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/sine_tone_with_envelope.sv =====
// sine_tone_with_envelope: DDS sine oscillator shaped by a four-quarter envelope.
// Each input transfer loads its sample straight into the output register.
// Throughput: one tick per cycle unless the output stalls; the table read, one 16x22
// multiply and the envelope add/subtract sit between note state and output register.
// Reset: all note state idle and cleared, registers at their defaults, output empty.
// Depends on stwe_pkg.
module sine_tone_with_envelope (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [stwe_pkg::CFG_W-1:0]          cfg_wdata,
	// tick input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_note,
	input  logic [stwe_pkg::STEP_W-1:0]         phase_step,
	// sample output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [stwe_pkg::SAMPLE_W-1:0] sample,
	output logic                                note_done
);
	import stwe_pkg::*;

	// configuration and derived quarter bounds
	logic [LEN_W-1:0]   note_length_q;
	logic [ASTEP_W-1:0] attack_step_q;
	logic [ASTEP_W-1:0] decay_step_q;
	logic [ENV_W-1:0]   start_level_q;
	logic [LEN_W-1:0]   q1_q;
	logic [LEN_W-1:0]   q2_q;
	logic [LEN_W-1:0]   q3_q;

	// note state
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_held_q;
	logic [ENV_W-1:0]      envelope_q;
	logic [LEN_W-1:0]      sample_index_q;
	logic                  playing_q;

	// combinational working values
	logic                  xfer;
	logic [LEN_W-1:0]      wr_len;
	logic [LEN_W+1:0]      wr_len3;
	logic [PHASE_BITS-1:0] ph;
	logic [PHASE_BITS-1:0] stp;
	logic [ENV_W-1:0]      env;
	logic [LEN_W-1:0]      idx_n;
	logic                  play;
	logic [ENV_W:0]        env_sum;
	logic [ENV_W-1:0]      env_added;
	logic [ENV_W-1:0]      env_subbed;
	logic [ENV_W-1:0]      env_out;
	logic [ENV_W-1:0]      env_next;
	logic [1:0]            quad;
	logic [SINE_TABLE_BITS-1:0] tab_idx;
	logic [TAB_AW-1:0]     tab_addr;
	logic [SINE_W-1:0]     sine_val;
	logic [SINE_W+ENV_W-1:0] prod;
	logic [SINE_W+ENV_W-1:0] prod_rnd;
	logic [SAMPLE_W-1:0]   mag;
	logic [SAMPLE_W-1:0]   smp;
	logic [LEN_W:0]        idx_inc;
	logic                  done;

	// a tick transfers whenever the output register is free or being emptied
	assign in_ready = !out_valid || out_ready;
	assign xfer     = in_valid && in_ready;

	assign wr_len  = cfg_wdata[LEN_W-1:0];
	assign wr_len3 = {2'b00, wr_len} + {1'b0, wr_len, 1'b0};

	// configuration registers, quarter bounds worked out on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_length_q <= NOTE_LEN_RST;
			attack_step_q <= ATTACK_STEP_RST;
			decay_step_q  <= DECAY_STEP_RST;
			start_level_q <= START_LEVEL_RST;
			q1_q          <= NOTE_LEN_RST >> 2;
			q2_q          <= NOTE_LEN_RST >> 1;
			q3_q          <= LEN_W'(({2'b00, NOTE_LEN_RST} + {1'b0, NOTE_LEN_RST, 1'b0}) >> 2);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NOTE_LENGTH: begin
					note_length_q <= wr_len;
					q1_q          <= wr_len >> 2;
					q2_q          <= wr_len >> 1;
					q3_q          <= wr_len3[LEN_W+1:2];
				end
				REG_ATTACK_STEP: attack_step_q <= cfg_wdata[ASTEP_W-1:0];
				REG_DECAY_STEP:  decay_step_q  <= cfg_wdata[ASTEP_W-1:0];
				REG_START_LEVEL: start_level_q <= cfg_wdata[ENV_W-1:0];
				default: ;
			endcase
		end
	end

	// a start tick restarts the note before the sample is made
	assign ph    = start_note ? '0 : phase_q;
	assign stp   = start_note ? PHASE_BITS'(phase_step) : step_held_q;
	assign env   = start_note ? start_level_q : envelope_q;
	assign idx_n = start_note ? '0 : sample_index_q;
	assign play  = start_note || playing_q;

	// envelope add saturates at the top, subtract clamps at zero
	assign env_sum    = {1'b0, env} + (ENV_W + 1)'(attack_step_q);
	assign env_added  = env_sum[ENV_W] ? ENV_MAX : env_sum[ENV_W-1:0];
	assign env_subbed = (ENV_W'(decay_step_q) >= env) ? '0 : env - ENV_W'(decay_step_q);

	// quarter select: attack and sustain use the old envelope, decay and release the new one
	always_comb begin
		if (idx_n < q1_q) begin
			env_out  = env;
			env_next = env_added;
		end else if (idx_n < q2_q) begin
			env_out  = env_subbed;
			env_next = env_subbed;
		end else if (idx_n < q3_q) begin
			env_out  = env;
			env_next = env;
		end else begin
			env_out  = env_subbed;
			env_next = env_subbed;
		end
	end

	// quarter-wave lookup, mirrored in odd quadrants
	assign quad     = ph[PHASE_BITS-1 -: 2];
	assign tab_idx  = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign tab_addr = quad[0] ? (TAB_AW'(TAB_N) - {1'b0, tab_idx}) : {1'b0, tab_idx};
	assign sine_val = SINE_ROM[tab_addr];

	// scale by the envelope, round half away; magnitude stays below 2^14
	assign prod     = (SINE_W + ENV_W)'(sine_val) * (SINE_W + ENV_W)'(env_out);
	assign prod_rnd = prod + ((SINE_W + ENV_W)'(1) << 22);
	assign mag      = {2'b00, prod_rnd[SINE_W+ENV_W-2:23]};
	assign smp      = quad[1] ? (SAMPLE_W'(0) - mag) : mag;

	assign idx_inc = {1'b0, idx_n} + (LEN_W + 1)'(1);
	assign done    = idx_inc >= {1'b0, note_length_q};

	// note state update on each tick transfer that plays or starts a note
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= '0;
			step_held_q    <= '0;
			envelope_q     <= '0;
			sample_index_q <= '0;
			playing_q      <= 1'b0;
		end else if (xfer && play) begin
			phase_q     <= ph + stp;
			step_held_q <= stp;
			envelope_q  <= env_next;
			playing_q   <= !done;
			if (!done) begin
				sample_index_q <= idx_inc[LEN_W-1:0];
			end else begin
				sample_index_q <= idx_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sample    <= '0;
			note_done <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
			if (in_valid) begin
				sample    <= play ? smp : '0;
				note_done <= play && done;
			end
		end
	end

endmodule

// ===== tb/tb_sine_tone_with_envelope.sv =====
// tb_sine_tone_with_envelope: self-checking testbench for the enveloped sine tone generator.
// Directed and random ticks against an in-bench predictor, with random idling on both sides.
// Depends on stwe_pkg and sine_tone_with_envelope.
module tb_sine_tone_with_envelope;
	timeunit 1ns;
	timeprecision 1ps;

	import stwe_pkg::*;

	// one expected output sample
	typedef struct {
		logic signed [SAMPLE_W-1:0] pcm;
		logic                       last;
	} tone_result_t;

	logic                       clk;
	logic                       arst_n     = 1'b0;
	logic                       cfg_we     = 1'b0;
	logic [1:0]                 cfg_index  = '0;
	logic [CFG_W-1:0]           cfg_wdata  = '0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic                       start_note = 1'b0;
	logic [STEP_W-1:0]          phase_step = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       note_done;

	// predictor copy of the registers
	logic [LEN_W-1:0]   cfg_len = NOTE_LEN_RST;
	logic [ASTEP_W-1:0] cfg_att = ATTACK_STEP_RST;
	logic [ASTEP_W-1:0] cfg_dec = DECAY_STEP_RST;
	logic [ENV_W-1:0]   cfg_lvl = START_LEVEL_RST;

	// predictor copy of the note state
	logic [PHASE_BITS-1:0] tone_phase = '0;
	logic [PHASE_BITS-1:0] tone_step  = '0;
	logic [ENV_W-1:0]      tone_env   = '0;
	logic [LEN_W-1:0]      tone_idx   = '0;
	bit                    tone_on    = 1'b0;

	logic [SINE_W-1:0] wave_rom [0:TAB_N];

	tone_result_t pending_tones [$];
	int mismatch_count = 0;

	// idling controls
	bit src_idle_on  = 1'b0;
	bit sink_idle_on = 1'b0;
	bit hold_req     = 1'b0;
	int stall_left   = 0;
	int hold_left    = 0;

	sine_tone_with_envelope i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_note (start_note),
		.phase_step (phase_step),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.note_done  (note_done)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	initial begin
		#(2_000_000);
		$display("FAIL");
		$finish;
	end

	// one quarter-wave entry: truncated Q30 Taylor series, rounded to Q1.15
	function automatic logic [SINE_W-1:0] quarter_wave_entry(int k);
		logic [63:0] x;
		logic [63:0] acc;
		logic [63:0] term;
		logic [63:0] v;
		x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
		acc  = x;
		term = x;
		for (int j = 1; j <= 8; j++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 64'((2 * j) * (2 * j + 1));
			if (j % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return SINE_W'(v);
	endfunction

	// envelope fall, clamped at zero
	function automatic logic [ENV_W-1:0] env_fall(logic [ENV_W-1:0] e, logic [ASTEP_W-1:0] d);
		return (32'(d) >= 32'(e)) ? '0 : ENV_W'(32'(e) - 32'(d));
	endfunction

	// envelope rise, saturated at the ceiling
	function automatic logic [ENV_W-1:0] env_rise(logic [ENV_W-1:0] e, logic [ASTEP_W-1:0] a);
		logic [31:0] s;
		s = 32'(e) + 32'(a);
		return (s > 32'(ENV_MAX)) ? ENV_MAX : ENV_W'(s);
	endfunction

	// sine at the current phase times the envelope, rounded and saturated
	function automatic logic [SAMPLE_W-1:0] shaped_sample(logic [PHASE_BITS-1:0] ph,
			logic [ENV_W-1:0] env);
		logic [1:0]                 quad;
		logic [SINE_TABLE_BITS-1:0] addr;
		logic [SINE_W-1:0]          s;
		logic [63:0]                mag;
		quad = ph[PHASE_BITS-1 -: 2];
		addr = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
		s    = quad[0] ? wave_rom[TAB_N - int'(addr)] : wave_rom[addr];
		mag  = (64'(s) * 64'(env) + (64'd1 << 22)) >> 23;
		if (quad[1]) begin
			if (mag > 64'd32768) begin
				mag = 64'd32768;
			end
			return SAMPLE_W'(64'h10000 - mag);
		end
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return SAMPLE_W'(mag);
	endfunction

	// next sample of the tone for one accepted tick
	function automatic tone_result_t tone_predict(bit st, logic [STEP_W-1:0] ps);
		tone_result_t r;
		logic [31:0]  len;
		logic [31:0]  q1;
		logic [31:0]  q2;
		logic [31:0]  q3;
		logic [31:0]  i;
		r.pcm  = '0;
		r.last = 1'b0;
		if (st) begin
			tone_phase = '0;
			tone_step  = PHASE_BITS'(ps);
			tone_env   = cfg_lvl;
			tone_idx   = '0;
			tone_on    = 1'b1;
		end
		if (tone_on) begin
			len = 32'(cfg_len);
			q1  = len / 4;
			q2  = len / 2;
			q3  = (len * 3) / 4;
			i   = 32'(tone_idx);
			// attack, decay, sustain, release
			if (i < q1) begin
				r.pcm    = shaped_sample(tone_phase, tone_env);
				tone_env = env_rise(tone_env, cfg_att);
			end else if (i < q2) begin
				tone_env = env_fall(tone_env, cfg_dec);
				r.pcm    = shaped_sample(tone_phase, tone_env);
			end else if (i < q3) begin
				r.pcm = shaped_sample(tone_phase, tone_env);
			end else begin
				tone_env = env_fall(tone_env, cfg_dec);
				r.pcm    = shaped_sample(tone_phase, tone_env);
			end
			tone_phase = tone_phase + tone_step;
			r.last     = ((i + 1) >= len);
			if (r.last) begin
				tone_on = 1'b0;
			end else begin
				tone_idx = tone_idx + LEN_W'(1);
			end
		end
		return r;
	endfunction

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left <= 80;
			out_ready <= 1'b0;
		end else if (!sink_idle_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(1, 14) - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each output transfer with the oldest expected sample
	always @(posedge clk) begin
		tone_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tones.size() == 0) begin
				$display("%0t: unexpected sample %0d, note_done %0b", $time, sample, note_done);
				mismatch_count++;
			end else begin
				want = pending_tones.pop_front();
				if (sample !== want.pcm) begin
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$time, want.pcm, sample);
					mismatch_count++;
				end
				if (note_done !== want.last) begin
					$display("%0t: note_done mismatch, expected %0b, actual %0b",
						$time, want.last, note_done);
					mismatch_count++;
				end
			end
		end
	end

	// one tick transfer; entered and left at a falling edge
	task automatic send_tick(bit st, logic [STEP_W-1:0] ps);
		tone_result_t next_tone;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		start_note <= st;
		phase_step <= ps;
		do begin
			@(posedge clk);
		end while (!in_ready);
		next_tone     = tone_predict(st, ps);
		pending_tones = {pending_tones, next_tone};
		@(negedge clk);
	endtask

	// stop offering ticks and let every expected sample come out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_tones.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(negedge clk);
	endtask

	// register write, mirrored into the predictor
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_NOTE_LENGTH: cfg_len = val[LEN_W-1:0];
			REG_ATTACK_STEP: cfg_att = val[ASTEP_W-1:0];
			REG_DECAY_STEP:  cfg_dec = val[ASTEP_W-1:0];
			default:         cfg_lvl = val[ENV_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// idle ticks and a note at the reset settings
	task automatic test_idle_and_defaults();
		send_tick(1'b0, '0);
		send_tick(1'b1, '1);
		send_tick(1'b0, 32'h0000_1234);
		send_tick(1'b1, 32'h4000_0000);
		settle_block();
	endtask

	// four-sample note through every quarter, then one- and zero-length notes
	task automatic test_short_notes();
		write_reg(REG_NOTE_LENGTH, 22'd4);
		write_reg(REG_ATTACK_STEP, 22'd1000);
		write_reg(REG_DECAY_STEP, 22'd300);
		write_reg(REG_START_LEVEL, 22'h10_0000);
		send_tick(1'b1, 32'h1357_9BDF);
		repeat (3) send_tick(1'b0, '1);
		send_tick(1'b0, '0);
		settle_block();
		write_reg(REG_NOTE_LENGTH, 22'd1);
		send_tick(1'b1, 32'h8000_0000);
		send_tick(1'b0, '0);
		settle_block();
		write_reg(REG_NOTE_LENGTH, 22'd0);
		send_tick(1'b1, 32'hC000_0001);
		settle_block();
	endtask

	// envelope saturating at the top and clamping at zero
	task automatic test_envelope_limits();
		write_reg(REG_NOTE_LENGTH, 22'd8);
		write_reg(REG_ATTACK_STEP, 22'hFFFF);
		write_reg(REG_DECAY_STEP, 22'hFFFF);
		write_reg(REG_START_LEVEL, CFG_W'(ENV_MAX));
		send_tick(1'b1, 32'h0840_0000);
		repeat (7) send_tick(1'b0, '0);
		settle_block();
		write_reg(REG_NOTE_LENGTH, 22'd4);
		write_reg(REG_ATTACK_STEP, 22'd0);
		write_reg(REG_START_LEVEL, 22'd100);
		send_tick(1'b1, 32'h2000_0000);
		repeat (3) send_tick(1'b0, '0);
		settle_block();
	endtask

	// shortening the note while it plays ends it on the next tick
	task automatic test_register_change_mid_note();
		write_reg(REG_NOTE_LENGTH, 22'd40);
		write_reg(REG_START_LEVEL, 22'h20_0000);
		write_reg(REG_ATTACK_STEP, 22'd5000);
		send_tick(1'b1, 32'h0123_4567);
		repeat (2) send_tick(1'b0, '0);
		settle_block();
		write_reg(REG_NOTE_LENGTH, 22'd2);
		send_tick(1'b0, '0);
		send_tick(1'b0, '0);
		settle_block();
	endtask

	// receiver holds off while ticks keep coming, so the input stalls
	task automatic test_output_holdoff();
		write_reg(REG_NOTE_LENGTH, 22'd64);
		write_reg(REG_DECAY_STEP, 22'd700);
		src_idle_on = 1'b0;
		hold_req    = 1'b1;
		send_tick(1'b1, 32'h0FED_CBA9);
		repeat (23) send_tick(1'b0, $urandom);
		settle_block();
		src_idle_on = 1'b1;
	endtask

	// random settings per phase, mostly whole notes with some restarts and idle ticks
	task automatic test_random_notes();
		logic [15:0]       r16;
		logic [ENV_W-1:0]  r22;
		bit                st;
		logic [STEP_W-1:0] ps;
		for (int p = 0; p < 8; p++) begin
			// both sides run flat out in the last phase
			src_idle_on  = (p != 7) && ($urandom_range(0, 3) != 0);
			sink_idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0:       r16 = 16'd4;
				1:       r16 = 16'hFFFF;
				2:       r16 = 16'($urandom_range(49, 400));
				default: r16 = 16'($urandom_range(4, 48));
			endcase
			write_reg(REG_NOTE_LENGTH, {6'($urandom), r16});
			for (int k = 0; k < 2; k++) begin
				case ($urandom_range(0, 5))
					0:       r16 = 16'd0;
					1:       r16 = 16'hFFFF;
					2:       r16 = 16'($urandom);
					default: r16 = 16'($urandom_range(0, 2000));
				endcase
				write_reg(k == 0 ? REG_ATTACK_STEP : REG_DECAY_STEP, {6'($urandom), r16});
			end
			case ($urandom_range(0, 5))
				0:       r22 = '0;
				1:       r22 = ENV_MAX;
				2:       r22 = ENV_W'($urandom);
				default: r22 = ENV_W'($urandom_range(0, 100000));
			endcase
			write_reg(REG_START_LEVEL, r22);
			for (int n = 0; n < 44; n++) begin
				if (!tone_on) begin
					st = ($urandom_range(0, 5) != 0);
				end else begin
					st = ($urandom_range(0, 24) == 0);
				end
				case ($urandom_range(0, 15))
					0:       ps = '0;
					1:       ps = '1;
					default: ps = $urandom;
				endcase
				send_tick(st, ps);
			end
			settle_block();
		end
	endtask

	initial begin
		for (int k = 0; k <= TAB_N; k++) begin
			wave_rom[k] = quarter_wave_entry(k);
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;

		test_idle_and_defaults();
		test_short_notes();
		test_envelope_limits();
		test_register_change_mid_note();
		test_output_holdoff();
		test_random_notes();

		settle_block();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0 && pending_tones.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
